/* hdl/tlba_pkg.sv */
// Shared types and constants for the tank level bar and alarm block.
`default_nettype none

package tlba_pkg;

    localparam int SEG_COUNT = 8;
    localparam int LEVEL_W = 10;
    localparam int LEVEL_FULL = 1000;
    localparam int CNT_W = $clog2(SEG_COUNT + 1);
    localparam int SCALE_W = $clog2(((2 ** LEVEL_W) - 1) * SEG_COUNT + 1);

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_ACK = 2'd1;
    localparam logic [1:0] MODE_COLLECT = 2'd2;
    localparam logic [1:0] MODE_STARTUP = 2'd3;

    localparam logic [1:0] ALARM_NOT_REQ = 2'd0;
    localparam logic [1:0] ALARM_STARTED = 2'd1;
    localparam logic [1:0] ALARM_FINISHED = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [LEVEL_W-1:0] level_tenths;
    } t_in_item;

    typedef struct packed {
        logic [SEG_COUNT-1:0] segments;
        logic [CNT_W-1:0]     level_count;
        logic [1:0]           alarm_state;
        logic                 start_alarm_pending;
        logic                 stop_alarm_pending;
        logic                 beep_pending;
        logic                 persist_write;
        logic [1:0]           persist_value;
    } t_out_item;

endpackage

`default_nettype wire

/* hdl/tank_level_bar_alarm.sv */
// Top level of the tank level bar and alarm block.
//
// Channel   Direction  Handshake            Payload
// in        input      i_in_valid/o_in_stall   i_in_item (t_in_item)
// out       output     o_out_valid/i_out_stall o_out_item (t_out_item)
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_data (saved alarm state)
//
// One item is accepted per cycle unless o_in_stall is high; it is captured in the input
// register, and its result is then captured in the result register before it leaves.
// Reset is synchronous and clears the bar, the count, the alarm state and all flags.
// A stalled result holds the pipeline, and the input stalls only while both registers
// are full and the output is stalled.
`default_nettype none

module tank_level_bar_alarm (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire tlba_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output tlba_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_data
);
    import tlba_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    logic [1:0] r_saved;
    logic       w_advance;
    logic       w_in_take;

    assign w_advance = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign w_in_take = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_saved <= ALARM_NOT_REQ;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_saved <= i_cfg_data;
            end
        end
        if (w_in_take) begin
            r_in_item <= i_in_item;
        end
    end

    tlba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance),
        .i_item   (r_in_item),
        .i_saved  (r_saved),
        .o_result (o_out_item)
    );

`ifndef SYNTHESIS
    a_persist_not_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.persist_write) |->
        (o_out_item.alarm_state != ALARM_STARTED &&
         o_out_item.persist_value == o_out_item.alarm_state))
        else $error("Persistence write reports a started or mismatched alarm state.");

    a_persist_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.persist_write) |->
        (o_out_item.persist_value == ALARM_NOT_REQ))
        else $error("Persistence value is not zero without a write.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.level_count <= CNT_W'(SEG_COUNT)))
        else $error("Level count exceeds the segment count.");
`endif

endmodule

`default_nettype wire

/* hdl/tlba_bar.sv */
// Bar segment hysteresis update and lit segment count.
`default_nettype none

module tlba_bar (
    input  wire logic [tlba_pkg::SEG_COUNT-1:0] i_seg,
    input  wire logic [tlba_pkg::LEVEL_W-1:0]   i_level,
    output logic      [tlba_pkg::SEG_COUNT-1:0] o_seg,
    output logic      [tlba_pkg::CNT_W-1:0]     o_count
);
    import tlba_pkg::*;

    logic [SCALE_W-1:0] w_scaled;

    assign w_scaled = SCALE_W'(i_level) * SCALE_W'(SEG_COUNT);

    always_comb begin
        for (int i = 0; i < SEG_COUNT; i++) begin
            if (w_scaled >= SCALE_W'((i + 1) * LEVEL_FULL)) begin
                o_seg[i] = 1'b1;
            end else if (w_scaled <= SCALE_W'(i * LEVEL_FULL)) begin
                o_seg[i] = 1'b0;
            end else begin
                o_seg[i] = i_seg[i];
            end
        end
    end

    always_comb begin
        o_count = '0;
        for (int i = 0; i < SEG_COUNT; i++) begin
            o_count = o_count + CNT_W'(o_seg[i]);
        end
    end

endmodule

`default_nettype wire

/* hdl/tlba_ctrl.sv */
// Alarm state machine, sticky flags, bar state and the result register.
`default_nettype none

module tlba_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire tlba_pkg::t_in_item  i_item,
    input  wire logic [1:0]          i_saved,
    output tlba_pkg::t_out_item      o_result
);
    import tlba_pkg::*;

    typedef enum logic [1:0] {
        S_NOT_REQ  = ALARM_NOT_REQ,
        S_STARTED  = ALARM_STARTED,
        S_FINISHED = ALARM_FINISHED
    } t_alarm;

    t_alarm               r_alarm, n_alarm;
    logic [SEG_COUNT-1:0] r_seg, n_seg;
    logic [CNT_W-1:0]     r_prev, n_prev;
    logic                 r_start, n_start;
    logic                 r_stop, n_stop;
    logic                 r_beep, n_beep;
    t_out_item            r_result, n_result;

    logic [SEG_COUNT-1:0] w_base;
    logic [SEG_COUNT-1:0] w_bar_seg;
    logic [CNT_W-1:0]     w_bar_count;
    logic                 w_pw;

    always_comb begin
        if (i_item.mode == MODE_STARTUP) begin
            w_base = '0;
        end else if (r_alarm != S_NOT_REQ) begin
            w_base = r_seg & {{(SEG_COUNT-1){1'b1}}, 1'b0};
        end else begin
            w_base = r_seg;
        end
    end

    tlba_bar u_bar (
        .i_seg   (w_base),
        .i_level (i_item.level_tenths),
        .o_seg   (w_bar_seg),
        .o_count (w_bar_count)
    );

    always_comb begin
        n_alarm = r_alarm;
        n_seg = r_seg;
        n_prev = r_prev;
        n_start = r_start;
        n_stop = r_stop;
        n_beep = r_beep;
        w_pw = 1'b0;
        case (i_item.mode)
            MODE_SAMPLE: begin
                if (w_bar_count == CNT_W'(SEG_COUNT) || w_bar_count == '0) begin
                    if (r_alarm == S_NOT_REQ) begin
                        n_start = 1'b1;
                        n_alarm = S_STARTED;
                    end
                end else begin
                    if (r_alarm == S_STARTED) begin
                        n_stop = 1'b1;
                    end
                    n_alarm = S_NOT_REQ;
                    if (r_prev != w_bar_count) begin
                        n_beep = 1'b1;
                    end
                end
                w_pw = (n_alarm != r_alarm) && (n_alarm != S_STARTED);
                n_seg = w_bar_seg;
                if (n_alarm == S_STARTED) begin
                    n_seg[0] = 1'b1;
                end
                n_prev = w_bar_count;
            end
            MODE_ACK: begin
                n_alarm = S_FINISHED;
            end
            MODE_COLLECT: begin
                n_start = 1'b0;
                n_stop = 1'b0;
                n_beep = 1'b0;
            end
            default: begin
                n_seg = w_bar_seg;
                n_prev = w_bar_count;
                case (i_saved)
                    ALARM_STARTED:  n_alarm = S_STARTED;
                    ALARM_FINISHED: n_alarm = S_FINISHED;
                    default:        n_alarm = S_NOT_REQ;
                endcase
            end
        endcase

        n_result.segments = n_seg;
        n_result.level_count = n_prev;
        n_result.alarm_state = n_alarm;
        n_result.persist_write = w_pw;
        n_result.persist_value = w_pw ? n_alarm : ALARM_NOT_REQ;
        if (i_item.mode == MODE_COLLECT) begin
            n_result.start_alarm_pending = r_start;
            n_result.stop_alarm_pending = r_stop;
            n_result.beep_pending = r_beep;
        end else begin
            n_result.start_alarm_pending = n_start;
            n_result.stop_alarm_pending = n_stop;
            n_result.beep_pending = n_beep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm <= S_NOT_REQ;
            r_seg <= '0;
            r_prev <= '0;
            r_start <= 1'b0;
            r_stop <= 1'b0;
            r_beep <= 1'b0;
        end else if (i_load) begin
            r_alarm <= n_alarm;
            r_seg <= n_seg;
            r_prev <= n_prev;
            r_start <= n_start;
            r_stop <= n_stop;
            r_beep <= n_beep;
        end
        if (i_load) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire
